@@ hdl/kpq_pkg.sv @@
// Shared types, constants and register indexes for the Kermit prefix/quote encoder.
// No dependencies; every other file of the block imports this package.
package kpq_pkg;

  localparam logic [7:0] LOW7_MASK  = 8'h7F;
  localparam logic [7:0] QUOTE_FLIP = 8'h40;
  localparam logic [7:0] DEL_CODE   = 8'h7F;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;
  localparam logic [7:0] CODE_LF    = 8'h0A;
  localparam logic [7:0] CODE_CR    = 8'h0D;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_PREFIX = 8'h26;  // '&'
  localparam logic [7:0] RST_CTLQ   = 8'h23;  // '#'
  localparam logic [7:0] RST_REPEAT = 8'h7E;  // '~'
  localparam logic       RST_CRLF   = 1'b0;

  // Configuration register indexes
  localparam logic [7:0] CFG_IDX_PREFIX = 8'd0;
  localparam logic [7:0] CFG_IDX_CTLQ   = 8'd1;
  localparam logic [7:0] CFG_IDX_REPEAT = 8'd2;
  localparam logic [7:0] CFG_IDX_CRLF   = 8'd3;

  // Request queue between classifier and emitter
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] prefix;
    logic [7:0] ctlq;
    logic [7:0] repeat_mk;
    logic       crlf;
  } kpq_cfg_t;

  // How the body of a request is emitted
  typedef enum logic [2:0] {
    KIND_CTL,    // ctlq, ctlq
    KIND_PRE,    // ctlq, prefix
    KIND_REP,    // ctlq, repeat marker
    KIND_PLAIN,  // value itself
    KIND_FLIP    // ctlq, value ^ 64
  } kpq_kind_t;

  typedef struct packed {
    kpq_kind_t  kind;
    logic       hi;     // emit the 8-bit prefix first
    logic [7:0] val;
  } kpq_req_t;

  function automatic logic is_printable(input logic [7:0] v);
    return (v >= PRINT_LO) && (v <= PRINT_HI);
  endfunction

endpackage

@@ hdl/kermit_prefix_quote_encoder.sv @@
// Top level of the Kermit prefix/quote encoder: config registers, classifier,
// request queue and emitter. Depends on kpq_pkg, kpq_front, kpq_queue, kpq_back.
// A byte's request is first written into the request queue; its first character is
//   then loaded into the emitter's output register and shown on the result ports.
// The emitter walks a byte's one to three characters, one character per cycle while
//   the result side keeps popping; with out_pop low the output register holds.
// Reset (synchronous, rst_n low): queue and emitter empty, registers back to
//   prefix '&', control quote '#', repeat '~', CR/LF translation off.
module kermit_prefix_quote_encoder
  import kpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_push,
  input  logic [7:0] in_byte,
  output logic       in_full,
  // result channel
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  kpq_cfg_t cfg_r, cfg_nxt;
  kpq_req_t front_req;
  kpq_req_t head_req;
  logic     q_empty;
  logic     q_pop;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_PREFIX: cfg_nxt.prefix    = cfg_data;
        CFG_IDX_CTLQ:   cfg_nxt.ctlq      = cfg_data;
        CFG_IDX_REPEAT: cfg_nxt.repeat_mk = cfg_data;
        CFG_IDX_CRLF:   cfg_nxt.crlf      = cfg_data[0];
        default:        cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prefix    <= RST_PREFIX;
      cfg_r.ctlq      <= RST_CTLQ;
      cfg_r.repeat_mk <= RST_REPEAT;
      cfg_r.crlf      <= RST_CRLF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify the incoming byte into a single emit request.
  kpq_front u_front (
    .in_byte (in_byte),
    .cfg     (cfg_r),
    .req     (front_req)
  );

  // Hold requests while the emitter works off multi-character ones; the
  // input side stalls only when this queue fills.
  kpq_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .wr_req (front_req),
    .full   (in_full),
    .pop    (q_pop),
    .rd_req (head_req),
    .empty  (q_empty)
  );

  // Expand the head request into characters; flag the final one.
  kpq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_req           (head_req),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .out_empty       (out_empty),
    .out_pop         (out_pop)
  );

endmodule

@@ hdl/kpq_front.sv @@
// Classifier: turns a raw byte into one emit request for the back end.
// Depends on kpq_pkg.
module kpq_front
  import kpq_pkg::*;
(
  input  logic [7:0] in_byte,
  input  kpq_cfg_t   cfg,
  output kpq_req_t   req
);

  logic [7:0] low;

  assign low = in_byte & LOW7_MASK;

  always_comb begin
    req.hi   = 1'b0;
    req.val  = in_byte;
    req.kind = KIND_PLAIN;
    priority if (in_byte == cfg.ctlq) begin
      req.kind = KIND_CTL;
    end else if (in_byte == cfg.prefix) begin
      req.kind = KIND_PRE;
    end else if (in_byte == cfg.repeat_mk) begin
      req.kind = KIND_REP;
    end else if (is_printable(in_byte)) begin
      req.kind = KIND_PLAIN;
    end else if ((in_byte < PRINT_LO) || (in_byte == DEL_CODE)) begin
      // raw CR/LF unless translation is on
      if (((in_byte == CODE_LF) || (in_byte == CODE_CR)) && !cfg.crlf) begin
        req.kind = KIND_PLAIN;
      end else begin
        req.kind = KIND_FLIP;
      end
    end else begin
      req.hi  = 1'b1;
      req.val = low;
      priority if (low == cfg.ctlq) begin
        req.kind = KIND_CTL;
      end else if (low == cfg.prefix) begin
        req.kind = KIND_PRE;
      end else if (low == cfg.repeat_mk) begin
        req.kind = KIND_REP;
      end else if (is_printable(low)) begin
        req.kind = KIND_PLAIN;
      end else begin
        req.kind = KIND_FLIP;
      end
    end
  end

endmodule

@@ hdl/kpq_queue.sv @@
// Short request queue decoupling the classifier from the emitter.
// Depends on kpq_pkg.
module kpq_queue
  import kpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  kpq_req_t wr_req,
  output logic     full,
  input  logic     pop,
  output kpq_req_t rd_req,
  output logic     empty
);

  kpq_req_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]     count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_req  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_req;
    end
  end

endmodule

@@ hdl/kpq_back.sv @@
// Emitter: expands the head request into one to three characters, one per
// cycle while the output register is free or being taken, through an output register. Depends on kpq_pkg.
module kpq_back
  import kpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  kpq_cfg_t   cfg,
  input  kpq_req_t   q_req,
  input  logic       q_empty,
  output logic       q_pop,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  output logic       out_empty,
  input  logic       out_pop
);

  logic [1:0] step_r, step_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       valid_r, valid_nxt;
  logic       load;
  logic [7:0] body0, body1;
  logic [1:0] body_n, count;
  logic [7:0] cur_char;
  logic       cur_last;

  // body characters of the head request
  always_comb begin
    body0  = cfg.ctlq;
    body1  = cfg.ctlq;
    body_n = 2'd2;
    unique case (q_req.kind)
      KIND_CTL:   body1 = cfg.ctlq;
      KIND_PRE:   body1 = cfg.prefix;
      KIND_REP:   body1 = cfg.repeat_mk;
      KIND_PLAIN: begin
        body0  = q_req.val;
        body_n = 2'd1;
      end
      KIND_FLIP:  body1 = q_req.val ^ QUOTE_FLIP;
      default:    body1 = cfg.ctlq;
    endcase
    count = body_n + {1'b0, q_req.hi};
  end

  always_comb begin
    unique case ({q_req.hi, step_r})
      3'b000:  cur_char = body0;
      3'b001:  cur_char = body1;
      3'b100:  cur_char = cfg.prefix;
      3'b101:  cur_char = body0;
      3'b110:  cur_char = body1;
      default: cur_char = body1;
    endcase
    cur_last = (step_r == count - 2'd1);
  end

  // advance when the output register is free or being taken
  assign load  = !valid_r || out_pop;
  assign q_pop = load && !q_empty && cur_last;

  always_comb begin
    step_nxt  = step_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        char_nxt = cur_char;
        last_nxt = cur_last;
        step_nxt = cur_last ? 2'd0 : step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_char        = char_r;
  assign out_last_of_run = last_r;
  assign out_empty       = !valid_r;

  // mid-request the head must still be in the queue
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != 2'd0) |-> !q_empty)
    else $error("emitter mid-request with empty queue");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != 2'd3)
    else $error("emitter step out of range");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (valid_r && last_r))
    else $error("request retired without a final character");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for kermit_prefix_quote_encoder: directed and random bytes
// under several register settings, checked against an in-bench encoder mirror.
// Depends on kpq_pkg and the encoder RTL.
module tb_top
  import kpq_pkg::*;
();

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_PCT      = 7;       // chance in a hundred that a side idles
  localparam int SETTLE_CYCLES = 8;       // output register plus margin
  localparam int CYCLE_LIMIT   = 200000;

  // Register indexes the encoder has no register for; writes must be dropped
  localparam logic [7:0] CFG_IDX_UNUSED_HI = 8'hFC;
  localparam logic [7:0] CFG_IDX_UNUSED_LO = 8'h04;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_push         = 1'b0;
  logic [7:0] in_byte         = 8'h00;
  logic       in_full;
  logic       out_empty;
  logic       out_pop         = 1'b0;
  logic [7:0] out_char;
  logic       out_last_of_run;
  logic       cfg_valid       = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index       = 8'h00;
  logic [7:0] cfg_data        = 8'h00;

  kpq_cfg_t    regs;        // mirror of the encoder's configuration registers
  logic [7:0]  byte_q[$];   // bytes waiting to be pushed
  enc_char_t   chars_due[$];  // characters the encoder still owes, oldest first
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  logic        calm       = 1'b0;  // set to suppress idling on both sides

  kermit_prefix_quote_encoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_byte         (in_byte),
    .in_full         (in_full),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Encoder mirror
  // ---------------------------------------------------------------------------
  function automatic logic in_print_range(input logic [7:0] v);
    return (v >= 8'h20) && (v <= 8'h7E);
  endfunction

  // Work out the characters one byte turns into and queue them as owed.
  // The first matching check wins, so coinciding registers resolve in this order.
  function automatic void kermit_encode(input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] seq [3];
    int         n;
    lo = b & LOW7_MASK;
    n  = 0;
    if (b == regs.ctlq) begin
      seq[0] = regs.ctlq;  seq[1] = regs.ctlq;      n = 2;
    end else if (b == regs.prefix) begin
      seq[0] = regs.ctlq;  seq[1] = regs.prefix;    n = 2;
    end else if (b == regs.repeat_mk) begin
      seq[0] = regs.ctlq;  seq[1] = regs.repeat_mk; n = 2;
    end else if (in_print_range(b)) begin
      seq[0] = b;          n = 1;
    end else if (b < PRINT_LO || b == DEL_CODE) begin
      // CR and LF go out raw unless translation is on
      if ((b == CODE_LF || b == CODE_CR) && !regs.crlf) begin
        seq[0] = b;        n = 1;
      end else begin
        seq[0] = regs.ctlq;  seq[1] = b ^ QUOTE_FLIP; n = 2;
      end
    end else begin
      // High bit set: prefix, then the low seven bits, quoted where needed (CR/LF always quoted)
      seq[0] = regs.prefix;
      if (lo == regs.ctlq) begin
        seq[1] = regs.ctlq;  seq[2] = regs.ctlq;      n = 3;
      end else if (lo == regs.prefix) begin
        seq[1] = regs.ctlq;  seq[2] = regs.prefix;    n = 3;
      end else if (lo == regs.repeat_mk) begin
        seq[1] = regs.ctlq;  seq[2] = regs.repeat_mk; n = 3;
      end else if (in_print_range(lo)) begin
        seq[1] = lo;         n = 2;
      end else begin
        seq[1] = regs.ctlq;  seq[2] = lo ^ QUOTE_FLIP; n = 3;
      end
    end
    for (int i = 0; i < n; i++) begin
      chars_due.push_back('{ch: seq[i], last: (i == n - 1)});
    end
  endfunction

  // Bias random bytes toward the ones that hit special branches
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = regs.ctlq;
      1: b = regs.prefix;
      2: b = regs.repeat_mk;
      3: b = regs.ctlq ^ 8'h80;
      4: b = regs.prefix ^ 8'h80;
      5: b = regs.repeat_mk ^ 8'h80;
      6: b = ($urandom_range(0, 1) ? CODE_CR : CODE_LF) |
             8'($urandom_range(0, 1) << 7);
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: push bytes from byte_q, predict each accepted request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full)
        kermit_encode(in_byte);
      // Hold the request while full; otherwise advance or idle
      if (!in_push || !in_full) begin
        if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_push <= 1'b1;
          in_byte <= byte_q.pop_front();
        end else begin
          in_push <= 1'b0;
          in_byte <= 8'($urandom_range(0, 255));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: pop characters and check them against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    enc_char_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (chars_due.size() == 0) begin
          report_mismatch($sformatf("char %h popped with nothing owed", out_char));
        end else begin
          want = chars_due.pop_front();
          if (out_char !== want.ch)
            report_mismatch($sformatf("out_char %h, want %h", out_char, want.ch));
          if (out_last_of_run !== want.last)
            report_mismatch($sformatf("out_last_of_run %b, want %b (char %h)",
                                      out_last_of_run, want.last, want.ch));
        end
      end
      out_pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  // Write one register; update the mirror at the handshake edge
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IDX_PREFIX: regs.prefix    = data;
      CFG_IDX_CTLQ:   regs.ctlq      = data;
      CFG_IDX_REPEAT: regs.repeat_mk = data;
      CFG_IDX_CRLF:   regs.crlf      = data[0];
      default: ;  // drop writes to unused indexes
    endcase
  endtask

  task automatic write_all(input logic [7:0] pre, input logic [7:0] ctl,
                           input logic [7:0] rep, input logic [7:0] crlf);
    write_reg(CFG_IDX_PREFIX, pre);
    write_reg(CFG_IDX_CTLQ, ctl);
    write_reg(CFG_IDX_REPEAT, rep);
    write_reg(CFG_IDX_CRLF, crlf);
  endtask

  // Wait until every byte is pushed and every owed character has come out
  task automatic settle();
    do @(posedge clk); while (byte_q.size() != 0 || in_push || chars_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queue some random bytes on top of whatever directed ones are queued, then drain
  task automatic run_phase(input int n_rand, input logic quiet);
    calm = quiet;
    repeat (n_rand) byte_q.push_back(pick_byte());
    settle();
  endtask

  initial begin
    regs = '{prefix: RST_PREFIX, ctlq: RST_CTLQ, repeat_mk: RST_REPEAT, crlf: RST_CRLF};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: extremes, printable edges, DEL, CR/LF raw, every quoted
    // special and its high-bit twin
    byte_q = {byte_q, 8'h00, 8'hFF, 8'h20, 8'h7E, 8'h7F, 8'h1F, 8'h0A, 8'h0D,
              8'h23, 8'h26, 8'h7E, 8'hA3, 8'hA6, 8'hFE, 8'h8A, 8'h8D,
              8'h80, 8'hA0, 8'h9F, 8'hC1, 8'h41, 8'h40};
    run_phase(0, 1'b0);

    // CR/LF translation on
    write_reg(CFG_IDX_CRLF, 8'h01);
    byte_q = {byte_q, 8'h0A, 8'h0D, 8'h8A, 8'h8D};
    run_phase(30, 1'b0);

    // Extremes; registers at 0x80 and above only ever match a whole byte,
    // and the translate bit keeps only bit 0 of the data
    write_all(8'h00, 8'hFF, 8'h80, 8'hFE);
    byte_q = {byte_q, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h0A, 8'h0D, 8'h01, 8'h81};
    run_phase(30, 1'b0);

    // Prefix and repeat coincide (prefix wins); DEL as the control quote
    write_all(8'h41, 8'h7F, 8'h41, 8'hFF);
    byte_q = {byte_q, 8'h41, 8'hC1, 8'h7F, 8'hFF, 8'h0D, 8'h8D};
    run_phase(30, 1'b0);

    // All three coincide on space (control quote wins); repeat is CR until its last write.
    // Writes to unused indexes must leave the registers alone.
    write_all(8'h20, 8'h20, 8'h0D, 8'h00);
    write_reg(CFG_IDX_UNUSED_HI, 8'hA5);
    write_reg(CFG_IDX_UNUSED_LO, 8'h5A);
    write_reg(CFG_IDX_REPEAT, 8'h20);
    byte_q = {byte_q, 8'h20, 8'hA0, 8'h0D, 8'h8D, 8'h0A};
    run_phase(25, 1'b0);

    // Random settings, no idling on either side
    write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_phase(40, 1'b1);

    // Back to the reset values by writing them
    write_all(RST_PREFIX, RST_CTLQ, RST_REPEAT, {7'd0, RST_CRLF});
    run_phase(10, 1'b0);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
